// ----- src/slm_pkg.sv -----
package slm_pkg;

  // Request queue geometry
  localparam int unsigned FIFO_DEPTH = 64;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Field widths
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned TS_W   = 32;
  localparam int unsigned ENTRY_W = SEQ_W + TS_W;

  // Register file
  localparam int unsigned APB_AW          = 3;
  localparam logic [31:0] MAX_DELAY_RESET = 32'd50000;
  localparam logic        REG_MAX_DELAY   = 1'b0;

  // Item kinds
  localparam logic ACT_REQUEST  = 1'b0;
  localparam logic ACT_RESPONSE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_QUEUED  = 3'd0,
    ST_DROPPED = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_STALE   = 3'd3,
    ST_MATCHED = 3'd4,
    ST_NOMATCH = 3'd5
  } status_e;

  // Next queue position, wrapping at the depth
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- src/slm_ram.sv -----
module slm_ram #(
  parameter int unsigned DATA_W = 64,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/slm_apb_regs.sv -----
module slm_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [slm_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [31:0]                max_delay_o
);

  logic [31:0] max_delay_q;
  logic [31:0] max_delay_d;
  logic        wr_en;
  logic        sel_max;

  // Word index decode: register 0 only
  assign sel_max = (paddr[2] == slm_pkg::REG_MAX_DELAY);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    max_delay_d = max_delay_q;
    if (wr_en && sel_max) begin
      max_delay_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delay_q <= slm_pkg::MAX_DELAY_RESET;
    end else begin
      max_delay_q <= max_delay_d;
    end
  end

  // Read back
  assign prdata      = sel_max ? max_delay_q : 32'd0;
  assign max_delay_o = max_delay_q;

endmodule

// ----- src/seq_matched_latency_monitor_unit.sv -----
// Sequence-matched latency monitor.
// Input channel: an item (action_i, seq_number_i, time_stamp_i) is taken at a
// clock edge with start high and busy low. A request (action 0) is stored in
// a 64-entry queue; a response (action 1) is matched against the queue head.
// Result channel: one result per item, shown for exactly one cycle with
// done_o high; the receiver must take it then and cannot stall the block.
// Flow: requests and responses to an empty queue give their result in the
// cycle after acceptance and keep busy low, so one such item per cycle.
// A response otherwise reads the head from the queue RAM (registered read)
// and then examines one entry per cycle: a stale head, a match or the last
// entry ends the search, and each skipped entry is dropped from the queue.
// busy is high for the whole search; the single RAM read port sets the
// search rate of one entry per cycle.
// Configuration: max_delay over an APB-style port at byte address 0; write
// only while no item is in flight.
// Reset: the queue is empty, max_delay is 50000; no clearing pass is needed
// since only written entries are ever read.
module seq_matched_latency_monitor_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Item channel
  input  logic                       start,
  output logic                       busy,
  input  logic                       action_i,
  input  logic [31:0]                seq_number_i,
  input  logic [31:0]                time_stamp_i,
  // Result channel
  output logic                       done_o,
  output logic [2:0]                 status_o,
  output logic signed [31:0]         delay_o,
  output logic                       late_o,
  output logic [31:0]                matched_seq_o,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [slm_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } fsm_e;

  fsm_e state_q, state_d;

  logic [slm_pkg::PTR_W-1:0]   head_q, head_d;
  logic [slm_pkg::PTR_W-1:0]   tail_q, tail_d;
  logic [slm_pkg::CNT_W-1:0]   count_q, count_d;
  logic                        first_q, first_d;
  logic [slm_pkg::SEQ_W-1:0]   rsp_seq_q, rsp_seq_d;
  logic [slm_pkg::TS_W-1:0]    rsp_ts_q, rsp_ts_d;

  logic                        done_q, done_d;
  slm_pkg::status_e            status_q, status_d;
  logic [31:0]                 delay_q, delay_d;
  logic                        late_q, late_d;
  logic [31:0]                 mseq_q, mseq_d;

  logic                        ram_we;
  logic                        ram_re;
  logic [slm_pkg::PTR_W-1:0]   ram_raddr;
  logic [slm_pkg::ENTRY_W-1:0] ram_rdata;
  logic [slm_pkg::SEQ_W-1:0]   ent_seq;
  logic [slm_pkg::TS_W-1:0]    ent_ts;
  logic [31:0]                 diff;
  logic                        accept;
  logic                        full;
  logic [31:0]                 max_delay;

  // Configuration registers
  slm_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_delay_o (max_delay)
  );

  // Request queue storage: {seq, time} per entry
  slm_ram #(
    .DATA_W (slm_pkg::ENTRY_W),
    .DEPTH  (slm_pkg::FIFO_DEPTH),
    .ADDR_W (slm_pkg::PTR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i ({seq_number_i, time_stamp_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy    = (state_q != S_IDLE);
  assign accept  = start & ~busy;
  assign full    = (count_q == slm_pkg::CNT_W'(slm_pkg::FIFO_DEPTH));
  assign ent_seq = ram_rdata[slm_pkg::ENTRY_W-1:slm_pkg::TS_W];
  assign ent_ts  = ram_rdata[slm_pkg::TS_W-1:0];
  assign diff    = rsp_ts_q - ent_ts;

  // Control: push, head read, and one-entry-per-cycle drain
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    first_d   = first_q;
    rsp_seq_d = rsp_seq_q;
    rsp_ts_d  = rsp_ts_q;
    done_d    = 1'b0;
    status_d  = status_q;
    delay_d   = 32'd0;
    late_d    = 1'b0;
    mseq_d    = 32'd0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == slm_pkg::ACT_REQUEST) begin
            done_d = 1'b1;
            if (full) begin
              status_d = slm_pkg::ST_DROPPED;
            end else begin
              ram_we   = 1'b1;
              tail_d   = slm_pkg::ptr_next(tail_q);
              count_d  = count_q + slm_pkg::CNT_W'(1);
              status_d = slm_pkg::ST_QUEUED;
            end
          end else if (count_q == '0) begin
            done_d   = 1'b1;
            status_d = slm_pkg::ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            rsp_seq_d = seq_number_i;
            rsp_ts_d  = time_stamp_i;
            first_d   = 1'b1;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (first_q && (rsp_seq_q < ent_seq)) begin
          // Response older than the head: leave the queue alone
          done_d   = 1'b1;
          status_d = slm_pkg::ST_STALE;
          state_d  = S_IDLE;
        end else begin
          head_d  = slm_pkg::ptr_next(head_q);
          count_d = count_q - slm_pkg::CNT_W'(1);
          first_d = 1'b0;
          if (ent_seq == rsp_seq_q) begin
            done_d   = 1'b1;
            status_d = slm_pkg::ST_MATCHED;
            delay_d  = diff;
            late_d   = ~diff[31] & ({1'b0, diff[30:0]} > max_delay);
            mseq_d   = ent_seq;
            state_d  = S_IDLE;
          end else if (count_q == slm_pkg::CNT_W'(1)) begin
            done_d   = 1'b1;
            status_d = slm_pkg::ST_NOMATCH;
            state_d  = S_IDLE;
          end else begin
            // Fetch the following entry while this one is dropped
            ram_re    = 1'b1;
            ram_raddr = slm_pkg::ptr_next(head_q);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      first_q <= first_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rsp_seq_q <= rsp_seq_d;
    rsp_ts_q  <= rsp_ts_d;
    status_q  <= status_d;
    delay_q   <= delay_d;
    late_q    <= late_d;
    mseq_q    <= mseq_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign delay_o       = delay_q;
  assign late_o        = late_q;
  assign matched_seq_o = mseq_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= slm_pkg::CNT_W'(slm_pkg::FIFO_DEPTH))
    else $error("queue count above depth");

  a_push_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == slm_pkg::ACT_REQUEST && !full) |=>
      (done_o && status_o == slm_pkg::ST_QUEUED))
    else $error("push without queued result");

  a_match_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == slm_pkg::ST_MATCHED) |-> $past(state_q == S_SCAN))
    else $error("match reported outside a search");

  a_late_only_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && late_o) |-> (status_o == slm_pkg::ST_MATCHED))
    else $error("late flag on a non-matched result");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (count_q != '0))
    else $error("search running on an empty queue");
`endif

endmodule

// ----- verif/tb_top.sv -----
module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned PHASE_ITEMS    = 120;
  localparam logic [slm_pkg::APB_AW-1:0] ADDR_MAX_DELAY =
    slm_pkg::APB_AW'({slm_pkg::REG_MAX_DELAY, 2'b00});
  // Byte address of register index 1, which does not exist
  localparam logic [slm_pkg::APB_AW-1:0] ADDR_SPARE = slm_pkg::APB_AW'(4);

  // One expected result
  typedef struct {
    slm_pkg::status_e   status;
    logic signed [31:0] delay;
    logic               late;
    logic [31:0]        mseq;
  } report_t;

  // Mirror of the request queue; computes the expected result of each item
  class latency_tracker;
    logic [31:0] seq_mem  [slm_pkg::FIFO_DEPTH];
    logic [31:0] time_mem [slm_pkg::FIFO_DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned count;
    logic [31:0] limit;
    report_t     pending_reports[$];
    int unsigned errors;

    function new();
      head   = 0;
      tail   = 0;
      count  = 0;
      limit  = slm_pkg::MAX_DELAY_RESET;
      errors = 0;
    endfunction

    // Entry idx places behind the head
    function void peek(input int unsigned idx, output logic [31:0] seq,
                       output logic [31:0] ts);
      seq = seq_mem[(head + idx) % slm_pkg::FIFO_DEPTH];
      ts  = time_mem[(head + idx) % slm_pkg::FIFO_DEPTH];
    endfunction

    // Accepted item: update the queue and queue up its result
    function void note_item(logic act, logic [31:0] seq, logic [31:0] ts);
      report_t     r;
      logic [31:0] es;
      logic [31:0] et;
      logic [31:0] d;
      bit          found;
      r.status = slm_pkg::ST_QUEUED;
      r.delay  = '0;
      r.late   = 1'b0;
      r.mseq   = '0;
      if (act == slm_pkg::ACT_REQUEST) begin
        if (count >= slm_pkg::FIFO_DEPTH) begin
          r.status = slm_pkg::ST_DROPPED;
        end else begin
          seq_mem[tail]  = seq;
          time_mem[tail] = ts;
          tail = (tail + 1) % slm_pkg::FIFO_DEPTH;
          count++;
        end
      end else if (count == 0) begin
        r.status = slm_pkg::ST_EMPTY;
      end else if (seq < seq_mem[head]) begin
        r.status = slm_pkg::ST_STALE;
      end else begin
        // pop until the sequence matches or the queue runs dry
        r.status = slm_pkg::ST_NOMATCH;
        found = 1'b0;
        while (count > 0 && !found) begin
          es = seq_mem[head];
          et = time_mem[head];
          head = (head + 1) % slm_pkg::FIFO_DEPTH;
          count--;
          if (es == seq) begin
            found    = 1'b1;
            d        = ts - et;
            r.status = slm_pkg::ST_MATCHED;
            r.delay  = d;
            r.mseq   = es;
            r.late   = (longint'($signed(d)) > longint'(limit));
          end
        end
      end
      pending_reports.push_back(r);
    endfunction

    // Result seen on the outputs: compare with the oldest expectation
    function void check_result(logic [2:0] st, logic signed [31:0] dl, logic lt,
                               logic [31:0] ms);
      report_t r;
      if (pending_reports.size() == 0) begin
        $error("result with no item outstanding: status %0d", st);
        errors++;
        return;
      end
      r = pending_reports.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        errors++;
      end
      if (dl !== r.delay) begin
        $error("delay: expected %0d, actual %0d", r.delay, dl);
        errors++;
      end
      if (lt !== r.late) begin
        $error("late: expected %0d, actual %0d", r.late, lt);
        errors++;
      end
      if (ms !== r.mseq) begin
        $error("matched_seq: expected %0h, actual %0h", r.mseq, ms);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         start        = 1'b0;
  logic                         busy;
  logic                         action_i     = 1'b0;
  logic [31:0]                  seq_number_i = '0;
  logic [31:0]                  time_stamp_i = '0;
  logic                         done_o;
  logic [2:0]                   status_o;
  logic signed [31:0]           delay_o;
  logic                         late_o;
  logic [31:0]                  matched_seq_o;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [slm_pkg::APB_AW-1:0]   paddr        = '0;
  logic [31:0]                  pwdata       = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  latency_tracker book = new();
  bit             gaps_on = 1'b1;
  int unsigned    items_sent = 0;
  int unsigned    quiet_cycles = 0;
  logic [31:0]    next_seq = '0;
  logic [31:0]    clock_now = '0;

  seq_matched_latency_monitor_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .seq_number_i  (seq_number_i),
    .time_stamp_i  (time_stamp_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .delay_o       (delay_o),
    .late_o        (late_o),
    .matched_seq_o (matched_seq_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      book.check_result(status_o, delay_o, late_o, matched_seq_o);
    end
  end

  // Watchdog: too long without any item or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Present one item, with optional idle cycles first; start stays high after
  task automatic send_item(logic act, logic [31:0] seq, logic [31:0] ts);
    while (gaps_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    action_i     <= act;
    seq_number_i <= seq;
    time_stamp_i <= ts;
    do begin
      @(posedge clk_i);
    end while (busy);
    book.note_item(act, seq, ts);
    items_sent++;
  endtask

  // One APB transfer; psel and penable are dropped after the access phase
  task automatic apb_access(logic wr, logic [slm_pkg::APB_AW-1:0] addr,
                            logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic verify_max_delay(logic [31:0] expected);
    logic [31:0] rd;
    apb_access(1'b0, ADDR_MAX_DELAY, '0, rd);
    if (rd !== expected) begin
      $error("max_delay: expected %0h, actual %0h", expected, rd);
      book.errors++;
    end
  endtask

  // Let every result come out, then settle
  task automatic wait_idle();
    start <= 1'b0;
    while (book.pending_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_max_delay(logic [31:0] value);
    logic [31:0] rd;
    wait_idle();
    apb_access(1'b1, ADDR_MAX_DELAY, value, rd);
    book.limit = value;
    verify_max_delay(value);
  endtask

  // Response time offsets around the interesting delay boundaries
  function automatic logic [31:0] response_lag();
    logic [31:0] lag;
    case ($urandom_range(5))
      0: lag = $urandom_range(1000);
      1: lag = book.limit - 1;
      2: lag = book.limit;
      3: lag = book.limit + 1;
      4: lag = -$urandom_range(1, 5000);
      default: lag = $urandom;
    endcase
    return lag;
  endfunction

  task automatic push_next();
    next_seq  = next_seq + $urandom_range(1, 3);
    clock_now = clock_now + $urandom_range(2000);
    send_item(slm_pkg::ACT_REQUEST, next_seq, clock_now);
  endtask

  task automatic answer_entry(int unsigned idx);
    logic [31:0] s;
    logic [31:0] t;
    book.peek(idx, s, t);
    send_item(slm_pkg::ACT_RESPONSE, s, t + response_lag());
  endtask

  // Fill the queue, push past full, then answer a random entry of the full queue
  task automatic fill_queue();
    int unsigned extra;
    extra = $urandom_range(1, 3);
    while (book.count < slm_pkg::FIFO_DEPTH) begin
      push_next();
    end
    repeat (extra) push_next();
    answer_entry($urandom_range(slm_pkg::FIFO_DEPTH - 1));
  endtask

  task automatic run_phase(int unsigned budget);
    int unsigned target;
    int unsigned kind;
    int unsigned n;
    logic [31:0] s;
    logic [31:0] t;
    target    = items_sent + budget;
    next_seq  = ($urandom_range(9) == 0) ? 32'hFFFF_FFF0 : $urandom_range(1 << 20);
    clock_now = ($urandom_range(3) == 0) ? 32'hFFFF_0000 : $urandom;
    while (items_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        // requests in order, then answers to the head or some later entry
        n = $urandom_range(1, 8);
        repeat (n) push_next();
        while (book.count > 0 && $urandom_range(99) < 70) begin
          answer_entry(($urandom_range(3) == 0) ? $urandom_range(book.count - 1) : 0);
        end
      end else if (kind < 75 && book.count > 0) begin
        // response older than the head, or a sequence beyond the queue when the head is 0
        book.peek(0, s, t);
        if (s != 0) begin
          send_item(slm_pkg::ACT_RESPONSE, $urandom_range(s - 1), $urandom);
        end else begin
          send_item(slm_pkg::ACT_RESPONSE, next_seq + 1, $urandom);
        end
      end else if (kind < 82 && book.count > 0) begin
        // sequence that is not queued: drains the queue unless it is below the head
        book.peek(0, s, t);
        send_item(slm_pkg::ACT_RESPONSE, next_seq + 32'd100, $urandom);
      end else if (kind < 84) begin
        fill_queue();
      end else begin
        send_item(1'($urandom_range(1)), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    logic [31:0] rd;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    verify_max_delay(slm_pkg::MAX_DELAY_RESET);

    // Directed cases at the reset limit
    send_item(slm_pkg::ACT_RESPONSE, 32'd7, 32'd0);                  // empty queue
    send_item(slm_pkg::ACT_REQUEST, 32'd0, 32'd0);
    send_item(slm_pkg::ACT_RESPONSE, 32'd0, 32'd0);                  // zero delay
    send_item(slm_pkg::ACT_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(slm_pkg::ACT_RESPONSE, 32'hFFFF_FFFF, 32'd4);          // time wraps
    send_item(slm_pkg::ACT_REQUEST, 32'd100, 32'd1000);
    send_item(slm_pkg::ACT_RESPONSE, 32'd99, 32'd2000);              // stale
    send_item(slm_pkg::ACT_RESPONSE, 32'd100, 32'd51000);            // at the limit
    send_item(slm_pkg::ACT_REQUEST, 32'd101, 32'd0);
    send_item(slm_pkg::ACT_RESPONSE, 32'd101, 32'd50001);            // just late
    send_item(slm_pkg::ACT_REQUEST, 32'd200, 32'd5000);
    send_item(slm_pkg::ACT_RESPONSE, 32'd200, 32'd4000);             // negative delay
    send_item(slm_pkg::ACT_REQUEST, 32'd300, 32'd10);
    send_item(slm_pkg::ACT_REQUEST, 32'd301, 32'd20);
    send_item(slm_pkg::ACT_REQUEST, 32'd302, 32'd30);
    send_item(slm_pkg::ACT_RESPONSE, 32'd302, 32'd90);               // skips two entries
    send_item(slm_pkg::ACT_REQUEST, 32'd400, 32'd0);
    send_item(slm_pkg::ACT_REQUEST, 32'd402, 32'd0);
    send_item(slm_pkg::ACT_RESPONSE, 32'd401, 32'd0);                // drains, no match
    send_item(slm_pkg::ACT_REQUEST, 32'd500, 32'd0);
    send_item(slm_pkg::ACT_RESPONSE, 32'd500, 32'h7FFF_FFFF);        // largest delay
    send_item(slm_pkg::ACT_REQUEST, 32'd600, 32'd0);
    send_item(slm_pkg::ACT_RESPONSE, 32'd600, 32'h8000_0000);        // most negative

    // Random phases over a range of limits
    wait_idle();
    fill_queue();
    run_phase(PHASE_ITEMS - 67);
    set_max_delay(32'd0);
    run_phase(PHASE_ITEMS);
    set_max_delay(32'hFFFF_FFFF);
    gaps_on = 1'b0;
    run_phase(PHASE_ITEMS);
    gaps_on = 1'b1;
    set_max_delay(32'h7FFF_FFFF);
    run_phase(PHASE_ITEMS);
    set_max_delay(32'h8000_0000);
    run_phase(PHASE_ITEMS);
    set_max_delay($urandom_range(100, 100000));
    run_phase(PHASE_ITEMS);
    set_max_delay(32'd1);
    run_phase(PHASE_ITEMS);
    set_max_delay($urandom);
    run_phase(PHASE_ITEMS);

    // A write to an unmapped address must leave the limit alone
    wait_idle();
    apb_access(1'b1, ADDR_SPARE, ~book.limit, rd);
    verify_max_delay(book.limit);
    set_max_delay(slm_pkg::MAX_DELAY_RESET);
    run_phase(PHASE_ITEMS);

    wait_idle();
    if (book.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
